/* src/itp_pkg.sv */
// Shared types and constants for the infix to postfix converter.
// Character codes, status codes, operator precedence and the stack control struct.
// No dependencies.
package itp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_POW   = 8'h5E;  // ^
  localparam logic [7:0] CH_ADD   = 8'h2B;  // +
  localparam logic [7:0] CH_SUB   = 8'h2D;  // -
  localparam logic [7:0] CH_MUL   = 8'h2A;  // *
  localparam logic [7:0] CH_DIV   = 8'h2F;  // /
  localparam logic [7:0] CH_MOD   = 8'h25;  // %
  localparam logic [7:0] CH_HASH  = 8'h23;  // #, unknown like any other

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_UNMATCH  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    case (c)
      CH_ADD, CH_SUB:         p = 2'd1;
      CH_MUL, CH_DIV, CH_MOD: p = 2'd2;
      CH_POW:                 p = 2'd3;
      default:                p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

/* src/itp_cell.sv */
// One entry of the shift-register operator stack.
// Takes its neighbor's entry on push or pop; uses itp_pkg::stk_ctl_t.
module itp_cell (
  input  logic             clk,
  input  itp_pkg::stk_ctl_t ctl,
  input  logic [7:0]       from_up,
  input  logic [7:0]       from_down,
  output logic [7:0]       data
);

  logic [7:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.push) begin
      data_next = from_up;
    end else if (ctl.pop) begin
      data_next = from_down;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* src/infix_to_postfix_converter_unit.sv */
// Infix to postfix converter (shunting-yard), top level.
// Uses itp_pkg and a row of itp_cell entries forming the operator stack.
// One character is taken per beat on the slave side and the postfix form leaves one
// character per beat on the master side. The block works on one character at a time.
// After the cycle that accepts a character, the block pops one stack entry per cycle
// and then takes a closing step, which pushes, emits or finishes the run; no step
// is taken while the output register is still held by the sink. The stack is a row
// of STACK_DEPTH cells that shift by one entry on each push or pop; the top and the
// entry below it are inspected each cycle to decide the next step. A push onto a full
// stack is dropped with an overflow status beat, an unmatched parenthesis gives
// status 2, and s_axis_tlast flushes the stack and emits a terminator beat.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,   // end_of_expr
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic [2:0] m_axis_tuser,   // [0] is_terminator, [2:1] status
  output logic       m_axis_tlast    // last_in_run
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic          state, state_next;
  logic [7:0]    sym;
  logic          eoe;
  logic          open_seen, open_seen_next;
  logic [CW-1:0] count, count_next;

  itp_pkg::stk_ctl_t ctl;
  logic [7:0] cell_q [STACK_DEPTH];

  logic       out_free;
  logic       emit, e_term, e_last, done;
  logic [7:0] e_sym;
  logic [1:0] e_st;
  logic [7:0] top, nxt;
  logic       empty, has2, full;
  logic       top_pops, nxt_pops;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [7:0] up_d, down_d;
      if (gi == 0) begin : g_first
        assign up_d = sym;
      end else begin : g_mid
        assign up_d = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_last
        assign down_d = 8'h00;
      end else begin : g_inner
        assign down_d = cell_q[gi+1];
      end
      itp_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .from_up  (up_d),
        .from_down(down_d),
        .data     (cell_q[gi])
      );
    end
  endgenerate

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign top   = cell_q[0];
  assign nxt   = cell_q[1];
  assign empty = (count == '0);
  assign has2  = (count > CW'(1));
  assign full  = (count == FULL);

  assign top_pops = (itp_pkg::prec(top) >= itp_pkg::prec(sym)) &&
                    !(top == itp_pkg::CH_POW && sym == itp_pkg::CH_POW);
  assign nxt_pops = (itp_pkg::prec(nxt) >= itp_pkg::prec(sym)) &&
                    !(nxt == itp_pkg::CH_POW && sym == itp_pkg::CH_POW);

  always_comb begin
    emit           = 1'b0;
    e_sym          = 8'h00;
    e_term         = 1'b0;
    e_st           = itp_pkg::STATUS_OK;
    e_last         = 1'b0;
    done           = 1'b0;
    ctl            = '0;
    open_seen_next = open_seen;
    if (state == ST_WORK && out_free) begin
      if (eoe) begin
        if (!empty) begin
          ctl.pop = 1'b1;
          if (top == itp_pkg::CH_OPEN) begin
            open_seen_next = 1'b1;
          end else begin
            emit  = 1'b1;
            e_sym = top;
          end
        end else begin
          emit   = 1'b1;
          e_term = 1'b1;
          e_st   = open_seen ? itp_pkg::STATUS_UNMATCH : itp_pkg::STATUS_OK;
          e_last = 1'b1;
          done   = 1'b1;
        end
      end else if (itp_pkg::is_alnum(sym)) begin
        emit   = 1'b1;
        e_sym  = sym;
        e_last = 1'b1;
        done   = 1'b1;
      end else if (sym == itp_pkg::CH_OPEN) begin
        done = 1'b1;
        if (full) begin
          emit   = 1'b1;
          e_st   = itp_pkg::STATUS_OVERFLOW;
          e_last = 1'b1;
        end else begin
          ctl.push = 1'b1;
        end
      end else if (sym == itp_pkg::CH_CLOSE) begin
        if (empty) begin
          emit   = 1'b1;
          e_st   = itp_pkg::STATUS_UNMATCH;
          e_last = 1'b1;
          done   = 1'b1;
        end else begin
          ctl.pop = 1'b1;
          if (top == itp_pkg::CH_OPEN) begin
            done = 1'b1;
          end else begin
            emit   = 1'b1;
            e_sym  = top;
            e_last = has2 && (nxt == itp_pkg::CH_OPEN);
          end
        end
      end else if (itp_pkg::prec(sym) != 2'd0) begin
        if (!empty && top_pops) begin
          ctl.pop = 1'b1;
          emit    = 1'b1;
          e_sym   = top;
          // push after the last pop always fits
          e_last  = !(has2 && nxt_pops);
        end else begin
          done = 1'b1;
          if (full) begin
            emit   = 1'b1;
            e_st   = itp_pkg::STATUS_OVERFLOW;
            e_last = 1'b1;
          end else begin
            ctl.push = 1'b1;
          end
        end
      end else begin
        done = 1'b1;
      end
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
    state_next = state;
    if (state == ST_IDLE && s_axis_tvalid) begin
      state_next = ST_WORK;
    end else if (done) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      open_seen     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_IDLE && s_axis_tvalid) begin
        open_seen <= 1'b0;
      end else begin
        open_seen <= open_seen_next;
      end
      if (out_free) begin
        m_axis_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      sym <= s_axis_tdata;
      eoe <= s_axis_tlast;
    end
    if (emit) begin
      m_axis_tdata <= e_sym;
      m_axis_tuser <= {e_st, e_term};
      m_axis_tlast <= e_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("stack count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !empty)
    else $error("pop from empty stack");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !full)
    else $error("push onto full stack");
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("terminator beat without tlast");

endmodule

/* verif/tb.sv */
// Self-checking testbench for infix_to_postfix_converter_unit (shunting-yard converter).
// Drives infix characters on the slave stream, predicts the postfix beats and checks the master stream.
// Depends on src/itp_pkg.sv and src/infix_to_postfix_converter_unit.sv.
module tb;

  localparam int STK_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] sym;
    logic       term;
    logic       last;
    logic [1:0] st;
  } postfix_beat_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] symbol
  logic       s_axis_tlast;   // end_of_expr
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;   // [7:0] out_symbol
  logic [2:0] m_axis_tuser;   // [0] is_terminator, [2:1] status
  logic       m_axis_tlast;   // last_in_run

  postfix_beat_t postfix_q[$];
  logic [7:0]    op_stack[STK_DEPTH];
  int            op_cnt = 0;
  int            useful_items = 0;
  int            errors = 0;
  int            burst_left = 0;
  int            idle_cycles = 0;
  int            rx_cyc = 0;
  logic [7:0]    expr_buf[$];

  infix_to_postfix_converter_unit #(.STACK_DEPTH(STK_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic int rank(input logic [7:0] c);
    case (c)
      itp_pkg::CH_ADD, itp_pkg::CH_SUB:                 return 1;
      itp_pkg::CH_MUL, itp_pkg::CH_DIV, itp_pkg::CH_MOD: return 2;
      itp_pkg::CH_POW:                                  return 3;
      default:                                          return 0;
    endcase
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic postfix_beat_t mk_beat(input logic [7:0] s, input logic t,
                                            input logic [1:0] st);
    postfix_beat_t b;
    b.sym = s;
    b.term = t;
    b.last = 1'b0;
    b.st = st;
    return b;
  endfunction

  // expected postfix beats for one accepted character
  task automatic convert_char(input logic [7:0] c, input logic eoe);
    postfix_beat_t run[$];
    logic [1:0]    st;
    logic          found;
    logic          push;
    logic [7:0]    t;
    int            r;
    st = itp_pkg::STATUS_OK;
    found = 1'b0;
    push = 1'b0;
    r = rank(c);
    if (eoe || is_operand(c) || c == itp_pkg::CH_OPEN || c == itp_pkg::CH_CLOSE || r > 0)
      useful_items++;
    if (eoe) begin
      while (op_cnt > 0) begin
        op_cnt--;
        t = op_stack[op_cnt];
        if (t == itp_pkg::CH_OPEN) st = itp_pkg::STATUS_UNMATCH;
        else run.push_back(mk_beat(t, 1'b0, itp_pkg::STATUS_OK));
      end
      run.push_back(mk_beat(8'h00, 1'b1, st));
    end else if (is_operand(c)) begin
      run.push_back(mk_beat(c, 1'b0, itp_pkg::STATUS_OK));
    end else if (c == itp_pkg::CH_OPEN) begin
      push = 1'b1;
    end else if (c == itp_pkg::CH_CLOSE) begin
      while (op_cnt > 0 && !found) begin
        op_cnt--;
        t = op_stack[op_cnt];
        if (t == itp_pkg::CH_OPEN) found = 1'b1;
        else run.push_back(mk_beat(t, 1'b0, itp_pkg::STATUS_OK));
      end
      if (!found) run.push_back(mk_beat(8'h00, 1'b0, itp_pkg::STATUS_UNMATCH));
    end else if (r > 0) begin
      // ^ is right-associative: it does not pop another ^
      while (op_cnt > 0 && rank(op_stack[op_cnt-1]) >= r &&
             !(c == itp_pkg::CH_POW && op_stack[op_cnt-1] == itp_pkg::CH_POW)) begin
        op_cnt--;
        run.push_back(mk_beat(op_stack[op_cnt], 1'b0, itp_pkg::STATUS_OK));
      end
      push = 1'b1;
    end
    if (push) begin
      if (op_cnt >= STK_DEPTH) begin
        run.push_back(mk_beat(8'h00, 1'b0, itp_pkg::STATUS_OVERFLOW));
      end else begin
        op_stack[op_cnt] = c;
        op_cnt++;
      end
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) postfix_q.push_back(run[i]);
  endtask

  task automatic report(input string what);
    if (errors < 40) $display("tb: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic eoe);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tdata = c;
    s_axis_tlast = eoe;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    convert_char(c, eoe);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    do @(negedge clk); while (postfix_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 5))
      0:       return itp_pkg::CH_ADD;
      1:       return itp_pkg::CH_SUB;
      2:       return itp_pkg::CH_MUL;
      3:       return itp_pkg::CH_DIV;
      4:       return itp_pkg::CH_MOD;
      default: return itp_pkg::CH_POW;
    endcase
  endfunction

  task automatic gen_term(input int lvl);
    if (lvl > 0 && $urandom_range(0, 2) == 0) begin
      expr_buf.push_back(itp_pkg::CH_OPEN);
      gen_expr(lvl - 1);
      expr_buf.push_back(itp_pkg::CH_CLOSE);
    end else begin
      expr_buf.push_back(rand_operand());
    end
  endtask

  task automatic gen_expr(input int lvl);
    int n;
    n = $urandom_range(0, 4);
    gen_term(lvl);
    repeat (n) begin
      expr_buf.push_back(rand_operator());
      gen_term(lvl);
    end
  endtask

  task automatic test_operators();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(itp_pkg::CH_HASH, 1'b0);
    send_text("0-Z*a^9^z/A%b+c");
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_parentheses();
    send_text("(a+b)*c)");
    send_char(8'h00, 1'b1);
    send_text("((d");
    send_char(8'h5A, 1'b1);
  endtask

  task automatic test_overflow();
    repeat (STK_DEPTH + 1) send_char(itp_pkg::CH_OPEN, 1'b0);
    send_char(itp_pkg::CH_CLOSE, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random_expressions();
    int goal;
    int k;
    logic [7:0] c;
    goal = useful_items + 150;
    while (useful_items < goal) begin
      expr_buf.delete();
      case ($urandom_range(0, 9))
        0: begin
          k = $urandom_range(10, STK_DEPTH + 3);
          repeat (k) expr_buf.push_back(itp_pkg::CH_OPEN);
          gen_expr(1);
          repeat ($urandom_range(0, k + 1)) expr_buf.push_back(itp_pkg::CH_CLOSE);
        end
        1: begin
          // long ^ chain fills the stack without popping
          expr_buf.push_back(rand_operand());
          expr_buf.push_back(itp_pkg::CH_ADD);
          repeat ($urandom_range(10, STK_DEPTH + 2)) begin
            expr_buf.push_back(rand_operand());
            expr_buf.push_back(itp_pkg::CH_POW);
          end
          expr_buf.push_back(rand_operand());
        end
        2: repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
        default: gen_expr($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 7) == 0 && expr_buf.size() > 1)
        expr_buf.delete($urandom_range(0, expr_buf.size() - 1));
      foreach (expr_buf[i]) begin
        c = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255)) : expr_buf[i];
        send_char(c, 1'b0);
      end
      send_char(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  // receiver stall pattern, cycles through four modes
  always @(negedge clk) begin
    rx_cyc++;
    case (rx_cyc[7:6])
      2'd0:    m_axis_tready = 1'b1;
      2'd1:    m_axis_tready = $urandom_range(0, 1);
      2'd2:    m_axis_tready = (rx_cyc[1:0] == 2'd0);
      default: m_axis_tready = ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin : check_beat
    postfix_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (postfix_q.size() == 0) begin
        report($sformatf("unexpected beat data %h user %b", m_axis_tdata, m_axis_tuser));
      end else begin
        want = postfix_q.pop_front();
        if (m_axis_tdata !== want.sym)
          report($sformatf("out_symbol %h, want %h", m_axis_tdata, want.sym));
        if (m_axis_tuser[0] !== want.term)
          report($sformatf("is_terminator %b, want %b", m_axis_tuser[0], want.term));
        if (m_axis_tlast !== want.last)
          report($sformatf("last_in_run %b, want %b", m_axis_tlast, want.last));
        if (m_axis_tuser[2:1] !== want.st)
          report($sformatf("status %0d, want %0d", m_axis_tuser[2:1], want.st));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_operators();
    test_parentheses();
    wait_drained();
    test_overflow();
    test_random_expressions();
    s_axis_tvalid = 1'b0;
    while (postfix_q.size() != 0) @(negedge clk);
    repeat (2 * STK_DEPTH + 8) @(negedge clk);
    if (errors == 0 && postfix_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
src/itp_pkg.sv
src/itp_cell.sv
src/infix_to_postfix_converter_unit.sv
verif/tb.sv
